>>> rtl/bva_pkg.sv
// ----------------------------------------------------------------------------
// bva_pkg
// Shared constants and types of the battery voltage averager.
// ----------------------------------------------------------------------------
package bva_pkg;

    // Ring depth and widths derived from it
    localparam int DEPTH   = 32;
    localparam int MV_W    = 13;                      // scaled millivolts
    localparam int RD_W    = 12;                      // converter reading
    localparam int SLOT_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int TOTAL_W = MV_W + SLOT_W;           // sum of DEPTH samples
    localparam int PROD_W  = MV_W + RD_W;             // full scale times reading

    // Shared divider: dividend shift register and divisor widths
    localparam int NUM_W   = TOTAL_W;
    localparam int DIVS_W  = RD_W;                    // holds reference and count
    localparam int STEP_W  = $clog2(NUM_W + 1);

    localparam logic [STEP_W-1:0] STEPS_SCALE = STEP_W'(MV_W);
    localparam logic [STEP_W-1:0] STEPS_AVG   = STEP_W'(NUM_W);

    localparam logic [MV_W-1:0] MV_MAX = {MV_W{1'b1}};

    // Stream widths, whole bytes
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;
    localparam int M_PAD_W   = M_TDATA_W - (2 * MV_W + 1);

    // Configuration register map
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 13;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REFERENCE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CRITICAL   = 2'd2;

    localparam logic [MV_W-1:0] FULL_SCALE_RST = 13'd4200;
    localparam logic [RD_W-1:0] REFERENCE_RST  = 12'd2000;
    localparam logic [MV_W-1:0] CRITICAL_RST   = 13'd3000;

    // Divider request and status
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

>>> rtl/bva_ram.sv
// ----------------------------------------------------------------------------
// bva_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/bva_div.sv
// ----------------------------------------------------------------------------
// bva_div
// Restoring divider, one quotient bit per cycle, shared by scaling and mean.
// ----------------------------------------------------------------------------
module bva_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  bva_pkg::div_req_t          req,
    input  logic [bva_pkg::DIVS_W-1:0] rem_init,
    input  logic [bva_pkg::NUM_W-1:0]  num_init,
    input  logic [bva_pkg::DIVS_W-1:0] divisor,
    output logic [bva_pkg::NUM_W-1:0]  quotient,
    output bva_pkg::div_stat_t         stat
);

    logic [bva_pkg::DIVS_W-1:0] rem_reg, rem_next;
    logic [bva_pkg::NUM_W-1:0]  num_reg, num_next;
    logic [bva_pkg::DIVS_W-1:0] dvs_reg;
    logic [bva_pkg::STEP_W-1:0] cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [bva_pkg::DIVS_W+1:0] trial;
    logic                       borrow;

    // Trial subtract of the divisor from the shifted partial remainder
    assign trial  = {1'b0, rem_reg, num_reg[bva_pkg::NUM_W-1]} - {2'b00, dvs_reg};
    assign borrow = trial[bva_pkg::DIVS_W+1];

    always_comb begin
        if (borrow) begin
            rem_next = {rem_reg[bva_pkg::DIVS_W-2:0], num_reg[bva_pkg::NUM_W-1]};
        end else begin
            rem_next = trial[bva_pkg::DIVS_W-1:0];
        end
        num_next = {num_reg[bva_pkg::NUM_W-2:0], ~borrow};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == bva_pkg::STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= rem_init;
            num_reg <= num_init;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            num_reg <= num_next;
        end
    end

    assign quotient  = num_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

>>> rtl/battery_voltage_averager_unit.sv
// ----------------------------------------------------------------------------
// battery_voltage_averager_unit
// Scales a converter reading to battery voltage and keeps a moving average.
// ----------------------------------------------------------------------------
// Each input transfer carries one calibrated reading in millivolts. The block
// scales it to full_scale_mv * reading / reference_reading (truncated,
// saturated at 8191; a zero reference saturates too), stores the result in a
// ring of 32 samples and returns one result transfer per input: the instant
// value, the truncated mean of the samples held so far (the divisor is the
// fill count until the ring is full) and a critical flag that is high when
// the instant value is below critical_mv. One restoring divider, one bit per
// cycle, does both divisions: 13 steps for the scaling and 18 for the mean.
// The scaling division is skipped when the scaled value saturates. s_tready
// rises at the same edge that raises m_tvalid, so a new reading is accepted
// only after the previous result is loaded into the output register. The
// result sits in that register, so a stalled master side only holds the
// block once the next result is ready. Write the configuration registers
// only while no item is in flight.
// ----------------------------------------------------------------------------
module battery_voltage_averager_unit (
    input  logic                          aclk,
    input  logic                          aresetn,

    // Input stream: [11:0] reading_mv
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bva_pkg::S_TDATA_W-1:0] s_tdata,

    // Result stream: [12:0] instant_mv, [25:13] average_mv, [26] critical
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bva_pkg::M_TDATA_W-1:0] m_tdata,

    // Configuration write port
    input  logic                          cfg_wr_en,
    input  logic [bva_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bva_pkg::CFG_W-1:0]     cfg_data
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE      = 3'd0;  // wait for a reading
    localparam logic [2:0] ST_SCALE     = 3'd1;  // saturate or start scaling
    localparam logic [2:0] ST_SDIV      = 3'd2;  // scaling division running
    localparam logic [2:0] ST_UPDATE    = 3'd3;  // ring and running total
    localparam logic [2:0] ST_AVG_START = 3'd4;  // start mean division
    localparam logic [2:0] ST_AVG       = 3'd5;  // mean division running
    localparam logic [2:0] ST_OUT       = 3'd6;  // hand result to output reg

    logic [2:0]                       state_reg, state_next;

    // Configuration registers
    logic [bva_pkg::MV_W-1:0]         full_scale_reg;
    logic [bva_pkg::RD_W-1:0]         reference_reg;
    logic [bva_pkg::MV_W-1:0]         critical_reg;

    // Datapath
    logic [bva_pkg::PROD_W-1:0]       prod_reg;
    logic [bva_pkg::MV_W-1:0]         inst_reg, inst_next;
    logic [bva_pkg::MV_W-1:0]         avg_reg;
    logic [bva_pkg::TOTAL_W-1:0]      total_reg, total_next;
    logic [bva_pkg::SLOT_W-1:0]       slot_reg, slot_next;
    logic [bva_pkg::CNT_W-1:0]        count_reg, count_next;
    logic                             ring_full;
    logic                             scale_sat;

    // Output register
    logic                             m_tvalid_reg;
    logic [bva_pkg::M_TDATA_W-1:0]    m_tdata_reg;
    logic                             out_free;

    // Ring memory
    logic                             ram_we;
    logic                             ram_re;
    logic [bva_pkg::MV_W-1:0]         ram_rdata;

    // Shared divider
    bva_pkg::div_req_t                div_req;
    bva_pkg::div_stat_t               div_stat;
    logic [bva_pkg::DIVS_W-1:0]       div_rem_init;
    logic [bva_pkg::NUM_W-1:0]        div_num_init;
    logic [bva_pkg::DIVS_W-1:0]       div_divisor;
    logic [bva_pkg::NUM_W-1:0]        div_quotient;

    logic                             s_xfer;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign ring_full = (count_reg == bva_pkg::CNT_W'(bva_pkg::DEPTH));
    assign out_free  = !m_tvalid_reg || m_tready;

    // A quotient of 8192 or more shows as product >= reference << 13; a zero
    // reference always lands here as well.
    assign scale_sat = (prod_reg >= {reference_reg, {bva_pkg::MV_W{1'b0}}});

    // ------------------------------------------------------------------
    // Configuration writes; bits above a register's width are dropped
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_scale_reg <= bva_pkg::FULL_SCALE_RST;
            reference_reg  <= bva_pkg::REFERENCE_RST;
            critical_reg   <= bva_pkg::CRITICAL_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bva_pkg::REG_FULL_SCALE: full_scale_reg <= cfg_data[bva_pkg::MV_W-1:0];
                bva_pkg::REG_REFERENCE:  reference_reg  <= cfg_data[bva_pkg::RD_W-1:0];
                bva_pkg::REG_CRITICAL:   critical_reg   <= cfg_data[bva_pkg::MV_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Divider request: scaling takes the high product bits as starting
    // remainder (below the reference once saturation is ruled out) and
    // shifts in the low 13 bits; the mean divides the whole total.
    // ------------------------------------------------------------------
    always_comb begin
        div_req.start = 1'b0;
        div_req.steps = bva_pkg::STEPS_AVG;
        div_rem_init  = '0;
        div_num_init  = total_reg;
        div_divisor   = bva_pkg::DIVS_W'(count_reg);
        if (state_reg == ST_SCALE) begin
            div_req.start = !scale_sat;
            div_req.steps = bva_pkg::STEPS_SCALE;
            div_rem_init  = prod_reg[bva_pkg::PROD_W-1:bva_pkg::MV_W];
            div_num_init  = {prod_reg[bva_pkg::MV_W-1:0],
                             {(bva_pkg::NUM_W - bva_pkg::MV_W){1'b0}}};
            div_divisor   = reference_reg;
        end else if (state_reg == ST_AVG_START) begin
            div_req.start = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        inst_next  = inst_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                if (scale_sat) begin
                    inst_next  = bva_pkg::MV_MAX;
                    state_next = ST_UPDATE;
                end else begin
                    state_next = ST_SDIV;
                end
            end
            ST_SDIV: begin
                if (div_stat.done) begin
                    inst_next  = div_quotient[bva_pkg::MV_W-1:0];
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:    state_next = ST_AVG_START;
            ST_AVG_START: state_next = ST_AVG;
            ST_AVG: begin
                if (div_stat.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Ring bookkeeping: drop the oldest sample from the total once full
    always_comb begin
        total_next = total_reg;
        slot_next  = slot_reg;
        count_next = count_reg;
        if (state_reg == ST_UPDATE) begin
            total_next = total_reg
                       - (ring_full ? bva_pkg::TOTAL_W'(ram_rdata) : '0)
                       + bva_pkg::TOTAL_W'(inst_reg);
            if (slot_reg == bva_pkg::SLOT_W'(bva_pkg::DEPTH - 1)) begin
                slot_next = '0;
            end else begin
                slot_next = slot_reg + 1'b1;
            end
            if (!ring_full) begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            total_reg <= '0;
            slot_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            total_reg <= total_next;
            slot_reg  <= slot_next;
            count_reg <= count_next;
        end
    end

    // Payload registers: product at acceptance, scaled sample, mean
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            prod_reg <= full_scale_reg * s_tdata[bva_pkg::RD_W-1:0];
        end
        inst_reg <= inst_next;
        if (state_reg == ST_AVG && div_stat.done) begin
            avg_reg <= div_quotient[bva_pkg::MV_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Output register: load when empty or being drained
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            m_tdata_reg <= {{bva_pkg::M_PAD_W{1'b0}},
                            (inst_reg < critical_reg),
                            avg_reg,
                            inst_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // Ring memory: read the slot about to be overwritten at acceptance,
    // write the new sample during the update
    // ------------------------------------------------------------------
    assign ram_re = s_xfer;
    assign ram_we = (state_reg == ST_UPDATE);

    bva_ram #(
        .WIDTH (bva_pkg::MV_W),
        .DEPTH (bva_pkg::DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (inst_reg),
        .re    (ram_re),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    bva_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .rem_init (div_rem_init),
        .num_init (div_num_init),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

`ifndef SYNTHESIS
    // Divider never runs while a new reading may be taken
    a_idle_div_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_stat.busy)
        else $error("divider busy while input is ready");

    // Division results only arrive in the states that wait for them
    a_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == ST_SDIV || state_reg == ST_AVG))
        else $error("divider done in unexpected state");

    // Fill count saturates at the ring depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= bva_pkg::CNT_W'(bva_pkg::DEPTH))
        else $error("fill count beyond ring depth");

    // Mean divisor is never zero
    a_avg_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_AVG_START) |-> (count_reg != '0))
        else $error("mean started with empty ring");

    // A saturated sample skips the scaling division
    a_sat_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCALE && scale_sat) |=> (state_reg == ST_UPDATE)
            && (inst_reg == bva_pkg::MV_MAX))
        else $error("saturated sample not clamped");
`endif

endmodule
